// ----- design/bswb_pkg.sv -----
// Package for the ballistic step and wall bounce unit.
// Shared widths, command and register codes, sequencer states, payload types
// and the saturation helper. No dependencies.
`timescale 1ns / 1ps

package bswb_pkg;

    localparam int MUL_A_W   = 49;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 52;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ELASTICITY   = 3'd5;

    localparam logic signed [31:0] RST_GRAVITY_X  = 32'sd0;
    localparam logic signed [31:0] RST_GRAVITY_Y  = -32'sd642908;
    localparam logic [30:0]        RST_FIELD      = 31'd6553600;
    localparam logic [30:0]        RST_RADIUS     = 31'd65536;
    localparam logic [15:0]        RST_ELASTICITY = 16'd32768;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_GT,
        S_T_GTT,
        S_T_VT,
        S_T_ACC,
        S_T_WR,
        S_R_CMP,
        S_R_MUL,
        S_R_WR,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        step_time;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_vel_x;
        logic signed [31:0] load_vel_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               out_of_bounds;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if ((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31])) begin
            r = x[31:0];
        end else if (x[ACC_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ----- design/ballistic_step_wall_bounce_unit.sv -----
// Top level of the ballistic step and wall bounce unit: sequencer, state,
// configuration registers and result register. Uses bswb_pkg and bswb_mul.
`timescale 1ns / 1ps

// One ball in signed Q16.16. With the result register free, a load or an
// unused command goes straight to the result register; a resolve compares,
// multiplies and writes back when a wall is hit and only compares otherwise;
// a tick uses the one registered 49x17 multiplier three times in series for
// each axis (g*dt, g*dt*dt, v*dt), then accumulates and rounds that axis,
// and a last step loads the result register. The input is taken only while
// the sequencer is idle; a finished result waits in its own register, so the
// next transaction can be accepted before it is taken. Configuration writes
// take effect at once and need no clearing pass.
module ballistic_step_wall_bounce_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bswb_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bswb_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [bswb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bswb_pkg::CFG_DAT_W-1:0]      cfg_wr_data
);
    import bswb_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] HALF_Q15 = ACC_W'(16384);

    seq_state_t state_reg, state_next;

    logic signed [31:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [30:0]        fw_reg, fw_next, fh_reg, fh_next, rad_reg, rad_next;
    logic [15:0]        el_reg, el_next;

    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;

    logic [15:0]               t_reg, t_next;
    logic                      axis_reg, axis_next;
    logic signed [MUL_A_W-1:0] gt_reg, gt_next;
    logic signed [ACC_W-1:0]   accp_reg, accp_next, accv_reg, accv_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic signed [31:0]      p_sel, v_sel, g_sel;
    logic signed [ACC_W-1:0] p_q16, v_q16, gt_ext, gtt_shr, prod_acc;
    logic signed [ACC_W-1:0] p_round, v_round, b_round;
    logic signed [31:0]      p_new, v_new, b_new;

    logic signed [32:0] px_w, py_w, r_w, lim_x, lim_y;
    logic               hit_left, hit_bottom, hit_right, hit_top, oob;

    bswb_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    assign p_sel = axis_reg ? py_reg : px_reg;
    assign v_sel = axis_reg ? vy_reg : vx_reg;
    assign g_sel = axis_reg ? gy_reg : gx_reg;

    assign p_q16    = {{(ACC_W-48){p_sel[31]}}, p_sel, 16'h0000};
    assign v_q16    = {{(ACC_W-48){v_sel[31]}}, v_sel, 16'h0000};
    assign gt_ext   = {{(ACC_W-MUL_A_W){gt_reg[MUL_A_W-1]}}, gt_reg};
    assign gtt_shr  = {{(ACC_W-(MUL_P_W-17)){mul_p[MUL_P_W-1]}}, mul_p[MUL_P_W-1:17]};
    assign prod_acc = mul_p[ACC_W-1:0];

    assign p_round = accp_reg + HALF_Q16;
    assign v_round = accv_reg + HALF_Q16;
    assign b_round = HALF_Q15 - prod_acc;
    assign p_new   = sat32(p_round >>> 16);
    assign v_new   = sat32(v_round >>> 16);
    assign b_new   = sat32(b_round >>> 15);

    assign px_w  = {px_reg[31], px_reg};
    assign py_w  = {py_reg[31], py_reg};
    assign r_w   = {2'b00, rad_reg};
    assign lim_x = {2'b00, fw_reg} - r_w;
    assign lim_y = {2'b00, fh_reg} - r_w;

    assign hit_left   = px_w < r_w;
    assign hit_bottom = py_w < r_w;
    assign hit_right  = px_w > lim_x;
    assign hit_top    = py_w > lim_y;
    assign oob        = hit_left || hit_bottom || hit_right || hit_top;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            axis_reg    <= 1'b0;
            gx_reg      <= RST_GRAVITY_X;
            gy_reg      <= RST_GRAVITY_Y;
            fw_reg      <= RST_FIELD;
            fh_reg      <= RST_FIELD;
            rad_reg     <= RST_RADIUS;
            el_reg      <= RST_ELASTICITY;
            px_reg      <= '0;
            py_reg      <= '0;
            vx_reg      <= '0;
            vy_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            axis_reg    <= axis_next;
            gx_reg      <= gx_next;
            gy_reg      <= gy_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            rad_reg     <= rad_next;
            el_reg      <= el_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            vx_reg      <= vx_next;
            vy_reg      <= vy_next;
        end
        t_reg      <= t_next;
        gt_reg     <= gt_next;
        accp_reg   <= accp_next;
        accv_reg   <= accv_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        axis_next    = axis_reg;
        t_next       = t_reg;
        gt_next      = gt_reg;
        accp_next    = accp_reg;
        accv_next    = accv_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        rad_next     = rad_reg;
        el_next      = el_reg;
        mul_a        = {{(MUL_A_W-32){v_sel[31]}}, v_sel};
        mul_b        = {1'b0, t_reg};

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_GRAVITY_X:    gx_next  = cfg_wr_data;
                REG_GRAVITY_Y:    gy_next  = cfg_wr_data;
                REG_FIELD_WIDTH:  fw_next  = cfg_wr_data[30:0];
                REG_FIELD_HEIGHT: fh_next  = cfg_wr_data[30:0];
                REG_BALL_RADIUS:  rad_next = cfg_wr_data[30:0];
                REG_ELASTICITY:   el_next  = cfg_wr_data[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    t_next    = s_data.step_time;
                    axis_next = 1'b0;
                    case (s_data.command)
                        CMD_LOAD: begin
                            px_next    = s_data.load_pos_x;
                            py_next    = s_data.load_pos_y;
                            vx_next    = s_data.load_vel_x;
                            vy_next    = s_data.load_vel_y;
                            state_next = S_DONE;
                        end
                        CMD_TICK:    state_next = S_T_GT;
                        CMD_RESOLVE: state_next = S_R_CMP;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_T_GT: begin
                mul_a      = {{(MUL_A_W-32){g_sel[31]}}, g_sel};
                state_next = S_T_GTT;
            end
            S_T_GTT: begin
                gt_next    = mul_p[MUL_A_W-1:0];
                mul_a      = mul_p[MUL_A_W-1:0];
                state_next = S_T_VT;
            end
            S_T_VT: begin
                accp_next  = p_q16 + gtt_shr;
                state_next = S_T_ACC;
            end
            S_T_ACC: begin
                accp_next  = accp_reg + prod_acc;
                accv_next  = v_q16 + gt_ext;
                state_next = S_T_WR;
            end
            S_T_WR: begin
                if (axis_reg) begin
                    py_next    = p_new;
                    vy_next    = v_new;
                    state_next = S_DONE;
                end else begin
                    px_next    = p_new;
                    vx_next    = v_new;
                    axis_next  = 1'b1;
                    state_next = S_T_GT;
                end
            end
            S_R_CMP: begin
                state_next = S_R_MUL;
                if (hit_left) begin
                    axis_next = 1'b0;
                    px_next   = {1'b0, rad_reg};
                end else if (hit_bottom) begin
                    axis_next = 1'b1;
                    py_next   = {1'b0, rad_reg};
                end else if (hit_right) begin
                    axis_next = 1'b0;
                    px_next   = lim_x[31:0];
                end else if (hit_top) begin
                    axis_next = 1'b1;
                    py_next   = lim_y[31:0];
                end else begin
                    state_next = S_DONE;
                end
            end
            S_R_MUL: begin
                mul_b      = {1'b0, el_reg};
                state_next = S_R_WR;
            end
            S_R_WR: begin
                if (axis_reg) begin
                    vy_next = b_new;
                end else begin
                    vx_next = b_new;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.pos_x         = px_reg;
                    m_data_next.pos_y         = py_reg;
                    m_data_next.vel_x         = vx_reg;
                    m_data_next.vel_y         = vy_reg;
                    m_data_next.out_of_bounds = oob;
                    state_next                = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- design/bswb_mul.sv -----
// Shared signed multiplier of the ballistic step unit, product registered.
// Depends on bswb_pkg for operand and product widths.
`timescale 1ns / 1ps

module bswb_mul (
    input  logic                                 aclk,
    input  logic signed [bswb_pkg::MUL_A_W-1:0]  mul_a,
    input  logic signed [bswb_pkg::MUL_B_W-1:0]  mul_b,
    output logic signed [bswb_pkg::MUL_P_W-1:0]  mul_p
);
    import bswb_pkg::*;

    logic signed [MUL_P_W-1:0] mul_p_reg;

    always_ff @(posedge aclk) begin
        mul_p_reg <= MUL_P_W'(mul_a * mul_b);
    end

    assign mul_p = mul_p_reg;

endmodule
